// ----- rtl/udp_econet_station_protocol_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the station protocol engine
// Shared shorthand for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef UDP_ECONET_STATION_PROTOCOL_TOP_MACROS_SVH
`define UDP_ECONET_STATION_PROTOCOL_TOP_MACROS_SVH

// Check that holds whenever the block is out of reset.
`define UESP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that holds on every edge, reset included.
`define UESP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/uesp_pkg.sv -----
// ----------------------------------------------------------------------------
// Station protocol package
// Types, codes and word layouts shared by the station protocol engine.
// ----------------------------------------------------------------------------
package uesp_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_RECEIVE  = 2'd0,
    KIND_TRANSMIT = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_e;

  // Result actions carried on the output tuser.
  typedef enum logic [3:0] {
    ACT_IGNORE      = 4'd0,
    ACT_ACK         = 4'd1,
    ACT_PEEK_REPLY  = 4'd2,
    ACT_DELIVER     = 4'd3,
    ACT_ACK_MATCHED = 4'd4,
    ACT_TRANSMIT    = 4'd5,
    ACT_RANGE       = 4'd6,
    ACT_CLASH       = 4'd7,
    ACT_NO_BUFFER   = 4'd8,
    ACT_SMALL       = 4'd9,
    ACT_NO_ADDRESS  = 4'd10
  } action_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_STATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_PORT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEEK_CONTROL   = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Header type codes.
  localparam logic [7:0] TYPE_UNICAST   = 8'd2;
  localparam logic [7:0] TYPE_ACK       = 8'd3;
  localparam logic [7:0] TYPE_IMMEDIATE = 8'd5;
  localparam logic [7:0] TYPE_REPLY     = 8'd6;

  localparam int unsigned HEADER_BYTES  = 8;
  localparam logic [15:0] FIXED_PORT    = 16'd32768;
  localparam logic [7:0]  DELIVER_FLAG  = 8'h80;
  localparam logic [7:0]  CONTROL_MASK  = 8'h7f;
  localparam logic [31:0] PEEK_PAYLOAD  = 32'h0360_0001;
  localparam logic [31:0] HANDLE_STEP   = 32'd4;
  localparam logic [31:0] SECONDS_MAX   = 32'hffff_ffff;

  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned OUT_TDATA_W = 152;

  // Input word, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] target_station;
    logic [11:0] buffer_capacity;
    logic        buffer_found;
    logic        wait_or_retry;
    logic [11:0] packet_length;
    logic [31:0] sequence_handle;
    logic [7:0]  control_byte;
    logic [7:0]  port_number;
    logic [7:0]  packet_type;
    logic [15:0] source_port;
    logic [31:0] source_ip;
  } in_data_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] reply_payload;
    logic [31:0] out_handle;
    logic [7:0]  out_control;
    logic [7:0]  out_port;
    logic [7:0]  out_type;
    logic [15:0] peer_port;
    logic [31:0] peer_ip;
    logic [7:0]  station;
    logic        accepted;
  } out_data_t;

  // One row of the per-station table.
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] rx_handle;
    logic [31:0] rx_expiry;
    logic [31:0] tx_handle;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

// ----- rtl/uesp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module uesp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents when the same entry is written.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/udp_econet_station_protocol_top.sv -----
// ----------------------------------------------------------------------------
// Econet-over-UDP station protocol engine
// Header filtering, acking, delivery, peek replies and transmit handles.
// ----------------------------------------------------------------------------
// Each input word is a received header, a transmit request or a one-second
// tick, and each one yields exactly one result word. A word is taken in the
// cycle it is offered as long as the previous one can move on, so the block
// sustains one word per clock while the output side keeps taking results;
// a word passes through the work stage and then the output register. The
// per-station table (address, UDP port, receive handle, receive expiry,
// transmit handle) sits in one memory row per station with a registered
// read, so the row is fetched in the cycle after acceptance and updated
// when the word leaves the work stage. When a word needs the row that the
// word ahead of it is just writing, the written row is forwarded instead
// of the memory data. A valid flop per station makes unwritten rows read
// as all zero, so no clearing pass is needed after reset. Configuration
// must only be written while the block is idle.
// ----------------------------------------------------------------------------
module udp_econet_station_protocol_top #(
  parameter int unsigned STATION_COUNT        = 256,
  parameter int unsigned RECEIVE_BUFFER_BYTES = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [uesp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [uesp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // From bit 0: source_ip, source_port, packet_type, port_number,
  // control_byte, sequence_handle, packet_length, wait_or_retry,
  // buffer_found, buffer_capacity, target_station, zero fill.
  input  logic [uesp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind
  input  logic [1:0]                          s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // From bit 0: accepted, station, peer_ip, peer_port, out_type, out_port,
  // out_control, out_handle, reply_payload, zero fill.
  output logic [uesp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // action
  output logic [3:0]                          m_axis_tuser
);

  import uesp_pkg::*;

  localparam int unsigned IdxW = $clog2(STATION_COUNT);
  // Lengths are compared in a width that holds the largest buffer size.
  localparam int unsigned LenW = 17;

  // Configuration registers.
  logic [7:0]  own_station_q;
  logic        fixed_port_q;
  logic [15:0] port_base_q;
  logic [7:0]  window_q;
  logic [7:0]  peek_control_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_station_q  <= 8'd0;
      fixed_port_q   <= 1'b0;
      port_base_q    <= 16'd10000;
      window_q       <= 8'd10;
      peek_control_q <= 8'd136;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OWN_STATION:    own_station_q  <= cfg_data_i[7:0];
        CFG_FIXED_PORT:     fixed_port_q   <= cfg_data_i[0];
        CFG_PORT_BASE:      port_base_q    <= cfg_data_i;
        CFG_RECEIVE_WINDOW: window_q       <= cfg_data_i[7:0];
        CFG_PEEK_CONTROL:   peek_control_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Accept side: work out the station so the table row can be fetched.
  in_data_t   in_data;
  kind_e      in_kind;
  logic       in_accept;
  logic [15:0] st_d;
  logic [IdxW-1:0] rd_addr;

  assign in_data   = in_data_t'(s_axis_tdata);
  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (in_kind == KIND_TRANSMIT) begin
      st_d = in_data.target_station;
    end else if (fixed_port_q && (in_data.source_port == FIXED_PORT)) begin
      st_d = {8'd0, in_data.source_ip[7:0]};
    end else begin
      st_d = in_data.source_port - port_base_q;
    end
  end

  assign rd_addr = st_d[IdxW-1:0];

  // Work stage registers.
  logic        s1_valid_q;
  kind_e       s1_kind_q;
  in_data_t    s1_data_q;
  logic [15:0] s1_st_q;
  logic        fwd_q;
  row_t        fwd_row_q;
  logic        row_vld_q;
  logic        s1_fire;

  // Protocol state.
  logic [STATION_COUNT-1:0] row_valid_q;
  logic        ltv_q, ltv_d;
  logic [7:0]  lti_q, lti_d;
  logic [31:0] seconds_q, seconds_d;

  // Table memory.
  logic        row_we;
  logic        ram_we;
  row_t        row_cur;
  row_t        row_new;
  logic [ROW_W-1:0] ram_rdata;
  logic [IdxW-1:0]  wr_addr;
  logic        fwd_hit;

  assign wr_addr = s1_st_q[IdxW-1:0];
  assign ram_we  = s1_fire && row_we;
  assign fwd_hit = ram_we && (wr_addr == rd_addr);

  uesp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STATION_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (row_new),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Output register.
  logic      out_valid_q;
  out_data_t out_data_q;
  action_e   out_action_q;
  out_data_t res;
  action_e   act;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      ltv_q       <= 1'b0;
      lti_q       <= 8'd0;
      seconds_q   <= 32'd1;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (s1_fire) begin
        ltv_q     <= ltv_d;
        lti_q     <= lti_d;
        seconds_q <= seconds_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q <= in_kind;
      s1_data_q <= in_data;
      s1_st_q   <= st_d;
      fwd_q     <= fwd_hit;
      fwd_row_q <= row_new;
      row_vld_q <= row_valid_q[rd_addr] || fwd_hit;
    end
    if (s1_fire) begin
      out_data_q   <= res;
      out_action_q <= act;
    end
  end

  // Work stage: decide the action and the updated table row.
  logic [LenW-1:0] len_ext;
  logic [LenW-1:0] len_c;
  logic [LenW-1:0] cap_lim;
  logic            too_short;
  logic            in_range;
  logic [32:0]     exp_sum;
  logic [31:0]     exp_sat;
  logic            fresh;
  logic [31:0]     tx_next;

  assign row_cur = fwd_q ? fwd_row_q : (row_vld_q ? row_t'(ram_rdata) : '0);

  assign len_ext   = LenW'(s1_data_q.packet_length);
  assign len_c     = (len_ext > LenW'(RECEIVE_BUFFER_BYTES)) ?
                     LenW'(RECEIVE_BUFFER_BYTES) : len_ext;
  assign too_short = len_c < LenW'(HEADER_BYTES);
  assign cap_lim   = LenW'(s1_data_q.buffer_capacity) + LenW'(HEADER_BYTES);
  assign in_range  = LenW'(s1_st_q) < LenW'(STATION_COUNT);

  // Expiry time saturates at the top of the counter.
  assign exp_sum = {1'b0, seconds_q} + {25'd0, window_q};
  assign exp_sat = exp_sum[32] ? SECONDS_MAX : exp_sum[31:0];
  assign fresh   = (s1_data_q.sequence_handle > row_cur.rx_handle) ||
                   (seconds_q > row_cur.rx_expiry);
  assign tx_next = s1_data_q.wait_or_retry ? row_cur.tx_handle :
                   row_cur.tx_handle + HANDLE_STEP;

  always_comb begin
    row_new   = row_cur;
    row_we    = 1'b0;
    act       = ACT_IGNORE;
    res       = '0;
    ltv_d     = ltv_q;
    lti_d     = lti_q;
    seconds_d = seconds_q;

    case (s1_kind_q)
      KIND_RECEIVE: begin
        if (!too_short) begin
          res.station = s1_st_q[7:0];
          if (!in_range) begin
            act = ACT_RANGE;
          end else if (s1_st_q == {8'd0, own_station_q}) begin
            act = ACT_CLASH;
          end else begin
            row_we = 1'b1;
            // An unknown station learns the sender's address and port.
            if (row_cur.addr == 32'd0) begin
              row_new.addr = s1_data_q.source_ip;
              row_new.port = s1_data_q.source_port;
            end
            if (row_new.addr != s1_data_q.source_ip) begin
              act = ACT_CLASH;
            end else if (s1_data_q.packet_type == TYPE_UNICAST) begin
              if (s1_data_q.wait_or_retry) begin
                act = ACT_IGNORE;
              end else if (fresh) begin
                row_new.rx_handle = s1_data_q.sequence_handle;
                row_new.rx_expiry = exp_sat;
                if (!s1_data_q.buffer_found) begin
                  act = ACT_NO_BUFFER;
                end else if (len_c > cap_lim) begin
                  act = ACT_SMALL;
                end else begin
                  act = ACT_DELIVER;
                end
              end else if (s1_data_q.sequence_handle == row_cur.rx_handle) begin
                // A repeat of the last handle is acked again.
                act = ACT_ACK;
              end
            end else if (s1_data_q.packet_type == TYPE_ACK) begin
              if (s1_data_q.wait_or_retry && ltv_q && (lti_q == s1_st_q[7:0]) &&
                  (s1_data_q.sequence_handle == row_cur.tx_handle)) begin
                act = ACT_ACK_MATCHED;
              end
            end else if ((s1_data_q.packet_type == TYPE_IMMEDIATE) &&
                         (s1_data_q.control_byte == peek_control_q)) begin
              act = ACT_PEEK_REPLY;
            end
          end
        end
      end
      KIND_TRANSMIT: begin
        res.station = s1_st_q[7:0];
        if (!in_range) begin
          act = ACT_RANGE;
        end else begin
          ltv_d = 1'b1;
          lti_d = s1_st_q[7:0];
          if (row_cur.addr == 32'd0) begin
            act = ACT_NO_ADDRESS;
          end else begin
            act               = ACT_TRANSMIT;
            row_we            = 1'b1;
            row_new.tx_handle = tx_next;
          end
        end
      end
      KIND_TICK: begin
        if (seconds_q != SECONDS_MAX) begin
          seconds_d = seconds_q + 32'd1;
        end
      end
      default: ;
    endcase

    // Header fields of the reply or outgoing packet.
    case (act)
      ACT_ACK, ACT_DELIVER: begin
        res.peer_ip     = s1_data_q.source_ip;
        res.peer_port   = s1_data_q.source_port;
        res.out_type    = TYPE_ACK;
        res.out_port    = s1_data_q.port_number;
        res.out_control = (act == ACT_DELIVER) ?
                          (s1_data_q.control_byte | DELIVER_FLAG) :
                          s1_data_q.control_byte;
        res.out_handle  = s1_data_q.sequence_handle;
      end
      ACT_PEEK_REPLY: begin
        res.peer_ip       = s1_data_q.source_ip;
        res.peer_port     = s1_data_q.source_port;
        res.out_type      = TYPE_REPLY;
        res.out_port      = s1_data_q.port_number;
        res.out_control   = s1_data_q.control_byte;
        res.out_handle    = s1_data_q.sequence_handle;
        res.reply_payload = PEEK_PAYLOAD;
      end
      ACT_TRANSMIT: begin
        res.peer_ip     = row_cur.addr;
        res.peer_port   = row_cur.port;
        res.out_type    = TYPE_UNICAST;
        res.out_port    = s1_data_q.port_number;
        res.out_control = s1_data_q.control_byte & CONTROL_MASK;
        res.out_handle  = tx_next;
      end
      default: ;
    endcase

    res.accepted = (act == ACT_DELIVER) || (act == ACT_ACK_MATCHED) ||
                   (act == ACT_TRANSMIT);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_action_q;

`include "udp_econet_station_protocol_top_macros.svh"

  `UESP_ASSERT(a_accepted_matches_action, m_axis_tvalid |-> (m_axis_tdata[0] == ((m_axis_tuser == ACT_DELIVER) || (m_axis_tuser == ACT_ACK_MATCHED) || (m_axis_tuser == ACT_TRANSMIT))), "accepted flag disagrees with action")
  `UESP_ASSERT(a_table_write_only_on_fire, ram_we |-> s1_fire, "table written without a finishing word")
  `UESP_ASSERT(a_seconds_monotonic, 1'b1 |=> (seconds_q >= $past(seconds_q)), "seconds counter went backward")
  `UESP_ASSERT(a_transmit_is_unicast, (m_axis_tvalid && (m_axis_tuser == ACT_TRANSMIT)) |-> (out_data_q.out_type == TYPE_UNICAST), "transmit result without unicast type")
  `UESP_ASSERT_ALWAYS(a_no_accept_while_held, (s1_valid_q && !s1_fire) |-> !in_accept, "word accepted while work stage is held")

endmodule
